// ----- rtl/smta_pkg.sv -----
// smta_pkg: shared constants, types and datapath command codes for the
// self motion tagging accumulator; no dependencies
package smta_pkg;

  localparam int OBS_DEPTH = 2048;
  localparam int OBS_AW    = $clog2(OBS_DEPTH);
  localparam int OBS_CW    = OBS_AW + 1;
  localparam int EXP_DEPTH = 256;
  localparam int EXP_AW    = $clog2(EXP_DEPTH);
  localparam int EXP_CW    = EXP_AW + 1;

  localparam int WIN_W   = 20;
  localparam int TIME_W  = 32;
  localparam int MV_W    = 32;
  localparam int ACC_W   = 27;
  localparam int CNT_W   = 12;
  localparam int LEN_W   = 17;
  localparam int OBS_WW  = TIME_W + MV_W + 1;
  localparam int EXP_WW  = TIME_W + MV_W;
  localparam int OUT_W   = 240;

  localparam int WIN_MIN_US = 1000;
  localparam int WIN_MAX_US = 100000;

  localparam logic [WIN_W-1:0] SELF_MATCH_RST = 20'd25000;
  localparam logic [WIN_W-1:0] LATE_RST       = 20'd10000;
  localparam logic [WIN_W-1:0] HISTORY_RST    = 20'd100000;

  localparam logic [1:0] REG_SELF_MATCH = 2'd0;
  localparam logic [1:0] REG_LATE       = 2'd1;
  localparam logic [1:0] REG_HISTORY    = 2'd2;

  localparam logic [1:0] OP_OBSERVE = 2'd0;
  localparam logic [1:0] OP_RECORD  = 2'd1;
  localparam logic [1:0] OP_CONSUME = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  typedef logic [4:0] cmd_t;

  localparam cmd_t CMD_NONE     = 5'd0;
  localparam cmd_t CMD_LOAD     = 5'd1;
  localparam cmd_t CMD_CLEAR    = 5'd2;
  localparam cmd_t CMD_ORD_HEAD = 5'd3;
  localparam cmd_t CMD_OPOP     = 5'd4;
  localparam cmd_t CMD_ERD_HEAD = 5'd5;
  localparam cmd_t CMD_EPOP     = 5'd6;
  localparam cmd_t CMD_REC_INIT = 5'd7;
  localparam cmd_t CMD_REC_RD   = 5'd8;
  localparam cmd_t CMD_REC_TAG  = 5'd9;
  localparam cmd_t CMD_REC_NEXT = 5'd10;
  localparam cmd_t CMD_EINS     = 5'd11;
  localparam cmd_t CMD_OBS_INIT = 5'd12;
  localparam cmd_t CMD_OBS_ERD  = 5'd13;
  localparam cmd_t CMD_OBS_NEXT = 5'd14;
  localparam cmd_t CMD_SETTAG   = 5'd15;
  localparam cmd_t CMD_SHIFT_RD = 5'd16;
  localparam cmd_t CMD_SHIFT_WR = 5'd17;
  localparam cmd_t CMD_EDEC     = 5'd18;
  localparam cmd_t CMD_OINS     = 5'd19;
  localparam cmd_t CMD_CON_INIT = 5'd20;
  localparam cmd_t CMD_CON_RD   = 5'd21;
  localparam cmd_t CMD_CON_ACC  = 5'd22;
  localparam cmd_t CMD_CON_END  = 5'd23;
  localparam cmd_t CMD_EMIT     = 5'd24;

  typedef struct packed {
    logic is_clear;
    logic is_consume;
    logic is_record;
    logic mv_zero;
    logic ocount_nz;
    logic ecount_nz;
    logic o_stale;
    logic e_stale;
    logic rec_more;
    logic rec_match;
    logic obs_more;
    logic obs_match;
    logic shift_more;
    logic con_more;
    logic front_le;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/smta_ctrl.sv -----
// smta_ctrl: sequencer that walks clear, prune, scan, shift, insert, consume and emit steps
// depends on smta_pkg for command codes and the status struct
module smta_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  smta_pkg::status_t st,
  output smta_pkg::cmd_t   cmd
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DISP    = 5'd1;
  localparam logic [4:0] S_OP_CHK  = 5'd2;
  localparam logic [4:0] S_OP_EV   = 5'd3;
  localparam logic [4:0] S_EP_CHK  = 5'd4;
  localparam logic [4:0] S_EP_EV   = 5'd5;
  localparam logic [4:0] S_BRANCH  = 5'd6;
  localparam logic [4:0] S_REC_CHK = 5'd7;
  localparam logic [4:0] S_REC_EV  = 5'd8;
  localparam logic [4:0] S_OBS_CHK = 5'd9;
  localparam logic [4:0] S_OBS_EV  = 5'd10;
  localparam logic [4:0] S_SH_CHK  = 5'd11;
  localparam logic [4:0] S_SH_WR   = 5'd12;
  localparam logic [4:0] S_OINS    = 5'd13;
  localparam logic [4:0] S_CON_CHK = 5'd14;
  localparam logic [4:0] S_CON_EV  = 5'd15;
  localparam logic [4:0] S_CF_CHK  = 5'd16;
  localparam logic [4:0] S_CF_EV   = 5'd17;
  localparam logic [4:0] S_EMIT    = 5'd18;

  logic [4:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = smta_pkg::CMD_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = smta_pkg::CMD_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (st.is_clear) begin
          cmd        = smta_pkg::CMD_CLEAR;
          state_next = S_IDLE;
        end else if (!st.is_consume && st.mv_zero) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_OP_CHK;
        end
      end
      S_OP_CHK: begin
        if (st.ocount_nz) begin
          cmd        = smta_pkg::CMD_ORD_HEAD;
          state_next = S_OP_EV;
        end else begin
          state_next = S_EP_CHK;
        end
      end
      S_OP_EV: begin
        if (st.o_stale) begin
          cmd        = smta_pkg::CMD_OPOP;
          state_next = S_OP_CHK;
        end else begin
          state_next = S_EP_CHK;
        end
      end
      S_EP_CHK: begin
        if (st.ecount_nz) begin
          cmd        = smta_pkg::CMD_ERD_HEAD;
          state_next = S_EP_EV;
        end else begin
          state_next = S_BRANCH;
        end
      end
      S_EP_EV: begin
        if (st.e_stale) begin
          cmd        = smta_pkg::CMD_EPOP;
          state_next = S_EP_CHK;
        end else begin
          state_next = S_BRANCH;
        end
      end
      S_BRANCH: begin
        if (st.is_consume) begin
          cmd        = smta_pkg::CMD_CON_INIT;
          state_next = S_CON_CHK;
        end else if (st.is_record) begin
          cmd        = smta_pkg::CMD_REC_INIT;
          state_next = S_REC_CHK;
        end else begin
          cmd        = smta_pkg::CMD_OBS_INIT;
          state_next = S_OBS_CHK;
        end
      end
      S_REC_CHK: begin
        if (st.rec_more) begin
          cmd        = smta_pkg::CMD_REC_RD;
          state_next = S_REC_EV;
        end else begin
          cmd        = smta_pkg::CMD_EINS;
          state_next = S_IDLE;
        end
      end
      S_REC_EV: begin
        if (st.rec_match) begin
          cmd        = smta_pkg::CMD_REC_TAG;
          state_next = S_IDLE;
        end else begin
          cmd        = smta_pkg::CMD_REC_NEXT;
          state_next = S_REC_CHK;
        end
      end
      S_OBS_CHK: begin
        if (st.obs_more) begin
          cmd        = smta_pkg::CMD_OBS_ERD;
          state_next = S_OBS_EV;
        end else begin
          state_next = S_OINS;
        end
      end
      S_OBS_EV: begin
        if (st.obs_match) begin
          cmd        = smta_pkg::CMD_SETTAG;
          state_next = S_SH_CHK;
        end else begin
          cmd        = smta_pkg::CMD_OBS_NEXT;
          state_next = S_OBS_CHK;
        end
      end
      S_SH_CHK: begin
        if (st.shift_more) begin
          cmd        = smta_pkg::CMD_SHIFT_RD;
          state_next = S_SH_WR;
        end else begin
          cmd        = smta_pkg::CMD_EDEC;
          state_next = S_OINS;
        end
      end
      S_SH_WR: begin
        cmd        = smta_pkg::CMD_SHIFT_WR;
        state_next = S_SH_CHK;
      end
      S_OINS: begin
        cmd        = smta_pkg::CMD_OINS;
        state_next = S_IDLE;
      end
      S_CON_CHK: begin
        if (st.con_more) begin
          cmd        = smta_pkg::CMD_CON_RD;
          state_next = S_CON_EV;
        end else begin
          cmd        = smta_pkg::CMD_CON_END;
          state_next = S_CF_CHK;
        end
      end
      S_CON_EV: begin
        cmd        = smta_pkg::CMD_CON_ACC;
        state_next = S_CON_CHK;
      end
      S_CF_CHK: begin
        if (st.ocount_nz) begin
          cmd        = smta_pkg::CMD_ORD_HEAD;
          state_next = S_CF_EV;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_CF_EV: begin
        if (st.front_le) begin
          cmd        = smta_pkg::CMD_OPOP;
          state_next = S_CF_CHK;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd        = smta_pkg::CMD_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/smta_dp.sv -----
// smta_dp: observed and expected ring stores, window registers, scan
// index, accumulators and output register; depends on smta_pkg
module smta_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  smta_pkg::cmd_t                cmd,
  output smta_pkg::status_t             st,
  input  logic [1:0]                    in_op,
  input  logic [63:0]                   in_data,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_idx,
  input  logic [smta_pkg::WIN_W-1:0]    cfg_val,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [smta_pkg::OUT_W-1:0]    out_data
);

  localparam int OAW = smta_pkg::OBS_AW;
  localparam int OCW = smta_pkg::OBS_CW;
  localparam int EAW = smta_pkg::EXP_AW;
  localparam int ECW = smta_pkg::EXP_CW;
  localparam int TW  = smta_pkg::TIME_W;
  localparam int AW  = smta_pkg::ACC_W;
  localparam int CW  = smta_pkg::CNT_W;
  localparam int LW  = smta_pkg::LEN_W;

  logic [smta_pkg::OBS_WW-1:0] omem [smta_pkg::OBS_DEPTH];
  logic [smta_pkg::EXP_WW-1:0] emem [smta_pkg::EXP_DEPTH];
  logic [smta_pkg::OBS_WW-1:0] ord;
  logic [smta_pkg::EXP_WW-1:0] erd;

  logic [smta_pkg::WIN_W-1:0] self_match_window, late_window, history_window;
  logic [1:0]    op;
  logic [31:0]   mv;
  logic [TW-1:0] now;
  logic [OAW-1:0] ohead;
  logic [OCW-1:0] ocount;
  logic [EAW-1:0] ehead;
  logic [ECW-1:0] ecount;
  logic [TW-1:0]  last_consume_time;
  logic [OCW-1:0] idx;
  logic           tag;
  logic signed [TW+1:0] start;
  logic [LW-1:0]  win_len;
  logic [AW-1:0]  raw_x, raw_y, self_x, self_y, man_x, man_y;
  logic [CW-1:0]  raw_cnt, self_cnt;
  logic [TW-1:0]  sample;

  logic           ofull, efull;
  logic [OAW-1:0] oslot_prev, oslot_cur, oslot_tail;
  logic [EAW-1:0] eslot_cur, eslot_nxt, eslot_tail;
  logic [TW-1:0]  ot, et, odiff, ediff;
  logic [31:0]    omv, emv;
  logic           otag;
  logic           owe, ore, ewe, ere;
  logic [OAW-1:0] owaddr, oraddr;
  logic [EAW-1:0] ewaddr, eraddr;
  logic [smta_pkg::OBS_WW-1:0] owdata;
  logic [smta_pkg::EXP_WW-1:0] ewdata;
  logic signed [TW+1:0] s_hist, s_lct, s_start, s_len;
  logic [LW-1:0]  len_clamped;
  logic           in_win;
  logic [AW-1:0]  ax, ay;

  assign ofull      = (ocount == OCW'(smta_pkg::OBS_DEPTH));
  assign efull      = (ecount == ECW'(smta_pkg::EXP_DEPTH));
  assign oslot_prev = ohead + idx[OAW-1:0] - OAW'(1);
  assign oslot_cur  = ohead + idx[OAW-1:0];
  assign oslot_tail = ohead + ocount[OAW-1:0];
  assign eslot_cur  = ehead + idx[EAW-1:0];
  assign eslot_nxt  = ehead + idx[EAW-1:0] + EAW'(1);
  assign eslot_tail = ehead + ecount[EAW-1:0];

  assign ot    = ord[TW-1:0];
  assign omv   = ord[TW+31:TW];
  assign otag  = ord[smta_pkg::OBS_WW-1];
  assign et    = erd[TW-1:0];
  assign emv   = erd[TW+31:TW];
  assign odiff = now - ot;
  assign ediff = now - et;

  // window start and clamped length
  always_comb begin
    s_hist  = $signed({2'b00, now}) - $signed({{(TW+2-smta_pkg::WIN_W){1'b0}}, history_window});
    s_lct   = $signed({2'b00, last_consume_time});
    s_start = (s_lct > s_hist) ? s_lct : s_hist;
    s_len   = $signed({2'b00, now}) - s_start;
    if (s_len < (TW+2)'(smta_pkg::WIN_MIN_US)) begin
      len_clamped = LW'(smta_pkg::WIN_MIN_US);
    end else if (s_len > (TW+2)'(smta_pkg::WIN_MAX_US)) begin
      len_clamped = LW'(smta_pkg::WIN_MAX_US);
    end else begin
      len_clamped = s_len[LW-1:0];
    end
  end

  assign in_win = ($signed({2'b00, ot}) > start) && (ot <= now);
  assign ax     = {{(AW-16){ord[TW+15]}}, ord[TW+15:TW]};
  assign ay     = {{(AW-16){ord[TW+31]}}, ord[TW+31:TW+16]};

  always_comb begin
    st.is_clear   = (op == smta_pkg::OP_CLEAR);
    st.is_consume = (op == smta_pkg::OP_CONSUME);
    st.is_record  = (op == smta_pkg::OP_RECORD);
    st.mv_zero    = (mv == 32'd0);
    st.ocount_nz  = (ocount != '0);
    st.ecount_nz  = (ecount != '0);
    st.o_stale    = (now > ot) && (odiff > {{(TW-smta_pkg::WIN_W){1'b0}}, history_window});
    st.e_stale    = (now > et) && (ediff > {{(TW-smta_pkg::WIN_W){1'b0}}, self_match_window});
    st.rec_more   = (idx != '0);
    st.rec_match  = !otag && (omv == mv) && (ot <= now) &&
                    (odiff <= {{(TW-smta_pkg::WIN_W){1'b0}}, late_window});
    st.obs_more   = (idx[ECW-1:0] < ecount);
    st.obs_match  = (emv == mv) && (now >= et) &&
                    (ediff <= {{(TW-smta_pkg::WIN_W){1'b0}}, self_match_window});
    st.shift_more = (({1'b0, idx[ECW-1:0]} + (ECW+1)'(1)) < {1'b0, ecount});
    st.con_more   = (idx < ocount);
    st.front_le   = (ot <= now);
    st.out_free   = !out_valid || out_ready;
  end

  // memory port decode
  always_comb begin
    owe    = 1'b0;
    ore    = 1'b0;
    ewe    = 1'b0;
    ere    = 1'b0;
    owaddr = oslot_tail;
    oraddr = ohead;
    ewaddr = eslot_tail;
    eraddr = ehead;
    owdata = {tag, mv, now};
    ewdata = {mv, now};
    case (cmd)
      smta_pkg::CMD_ORD_HEAD: begin
        ore = 1'b1;
      end
      smta_pkg::CMD_REC_RD: begin
        ore    = 1'b1;
        oraddr = oslot_prev;
      end
      smta_pkg::CMD_CON_RD: begin
        ore    = 1'b1;
        oraddr = oslot_cur;
      end
      smta_pkg::CMD_REC_TAG: begin
        owe    = 1'b1;
        owaddr = oslot_prev;
        owdata = {1'b1, ord[smta_pkg::OBS_WW-2:0]};
      end
      smta_pkg::CMD_OINS: begin
        owe    = 1'b1;
        owaddr = ofull ? ohead : oslot_tail;
      end
      smta_pkg::CMD_ERD_HEAD: begin
        ere = 1'b1;
      end
      smta_pkg::CMD_OBS_ERD: begin
        ere    = 1'b1;
        eraddr = eslot_cur;
      end
      smta_pkg::CMD_SHIFT_RD: begin
        ere    = 1'b1;
        eraddr = eslot_nxt;
      end
      smta_pkg::CMD_SHIFT_WR: begin
        ewe    = 1'b1;
        ewaddr = eslot_cur;
        ewdata = erd;
      end
      smta_pkg::CMD_EINS: begin
        ewe    = 1'b1;
        ewaddr = efull ? ehead : eslot_tail;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (owe) begin
      omem[owaddr] <= owdata;
    end
    if (ore) begin
      ord <= omem[oraddr];
    end
    if (ewe) begin
      emem[ewaddr] <= ewdata;
    end
    if (ere) begin
      erd <= emem[eraddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      self_match_window <= smta_pkg::SELF_MATCH_RST;
      late_window       <= smta_pkg::LATE_RST;
      history_window    <= smta_pkg::HISTORY_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        smta_pkg::REG_SELF_MATCH: self_match_window <= cfg_val;
        smta_pkg::REG_LATE:       late_window       <= cfg_val;
        smta_pkg::REG_HISTORY:    history_window    <= cfg_val;
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ohead             <= '0;
      ocount            <= '0;
      ehead             <= '0;
      ecount            <= '0;
      last_consume_time <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (cmd == smta_pkg::CMD_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd)
        smta_pkg::CMD_CLEAR: begin
          ohead             <= '0;
          ocount            <= '0;
          ecount            <= '0;
          last_consume_time <= now;
        end
        smta_pkg::CMD_OPOP: begin
          ohead  <= ohead + OAW'(1);
          ocount <= ocount - OCW'(1);
        end
        smta_pkg::CMD_EPOP: begin
          ehead  <= ehead + EAW'(1);
          ecount <= ecount - ECW'(1);
        end
        smta_pkg::CMD_EDEC: begin
          ecount <= ecount - ECW'(1);
        end
        smta_pkg::CMD_EINS: begin
          if (efull) begin
            ehead <= ehead + EAW'(1);
          end else begin
            ecount <= ecount + ECW'(1);
          end
        end
        smta_pkg::CMD_OINS: begin
          if (ofull) begin
            ohead <= ohead + OAW'(1);
          end else begin
            ocount <= ocount + OCW'(1);
          end
        end
        smta_pkg::CMD_CON_END: begin
          last_consume_time <= now;
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd)
      smta_pkg::CMD_LOAD: begin
        op  <= in_op;
        mv  <= in_data[31:0];
        now <= in_data[63:32];
      end
      smta_pkg::CMD_REC_INIT: begin
        idx <= ocount;
      end
      smta_pkg::CMD_REC_NEXT: begin
        idx <= idx - OCW'(1);
      end
      smta_pkg::CMD_OBS_INIT: begin
        idx <= '0;
        tag <= 1'b0;
      end
      smta_pkg::CMD_OBS_NEXT, smta_pkg::CMD_SHIFT_WR: begin
        idx <= idx + OCW'(1);
      end
      smta_pkg::CMD_SETTAG: begin
        tag <= 1'b1;
      end
      smta_pkg::CMD_CON_INIT: begin
        idx      <= '0;
        start    <= s_start;
        win_len  <= len_clamped;
        sample   <= now;
        raw_x    <= '0;
        raw_y    <= '0;
        self_x   <= '0;
        self_y   <= '0;
        man_x    <= '0;
        man_y    <= '0;
        raw_cnt  <= '0;
        self_cnt <= '0;
      end
      smta_pkg::CMD_CON_ACC: begin
        idx <= idx + OCW'(1);
        if (in_win) begin
          raw_x   <= raw_x + ax;
          raw_y   <= raw_y + ay;
          raw_cnt <= raw_cnt + CW'(1);
          if (otag) begin
            self_x   <= self_x + ax;
            self_y   <= self_y + ay;
            self_cnt <= self_cnt + CW'(1);
          end else begin
            man_x  <= man_x + ax;
            man_y  <= man_y + ay;
            sample <= ot;
          end
        end
      end
      smta_pkg::CMD_EMIT: begin
        out_data <= {5'd0, win_len, sample, man_y, man_x, self_cnt, self_y, self_x,
                     raw_cnt, raw_y, raw_x};
      end
      default: begin
      end
    endcase
  end

  a_ocount_bound: assert property (@(posedge clk) disable iff (rst)
    ocount <= OCW'(smta_pkg::OBS_DEPTH))
    else $error("observed count past depth");

  a_ecount_bound: assert property (@(posedge clk) disable iff (rst)
    ecount <= ECW'(smta_pkg::EXP_DEPTH))
    else $error("expected count past depth");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd == smta_pkg::CMD_EMIT) |-> (!out_valid || out_ready))
    else $error("result overwrites a waiting result");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd == smta_pkg::CMD_CLEAR) |=> (ocount == '0 && ecount == '0))
    else $error("clear left entries");

endmodule

// ----- rtl/self_motion_tagging_accumulator.sv -----
// self_motion_tagging_accumulator: top level joining sequencer and datapath
// depends on smta_pkg, smta_ctrl and smta_dp
// throughput: one item at a time; a waiting result holds the next consume at its emit
// reset: synchronous, empties both stores, window registers to defaults
module self_motion_tagging_accumulator (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [63:0]   s_axis_tdata,   // move_x, move_y, stamp
  input  logic [1:0]    s_axis_tuser,   // op
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [239:0]  m_axis_tdata,   // raw_x, raw_y, raw_count, self_x, self_y,
                                        // self_count, manual_x, manual_y,
                                        // sample_time, window_length
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [19:0]   cfg_data
);

  smta_pkg::cmd_t    cmd;
  smta_pkg::status_t st;

  assign cfg_ready = 1'b1;

  smta_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  smta_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_op     (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_val   (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// ----- sim/testbench.sv -----
// testbench for self_motion_tagging_accumulator: directed table, then random
// items checked against a behavioral predictor; depends on smta_pkg and the rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [smta_pkg::LEN_W-1:0]  window_length;
    logic [smta_pkg::TIME_W-1:0] sample_time;
    logic [smta_pkg::ACC_W-1:0]  manual_y;
    logic [smta_pkg::ACC_W-1:0]  manual_x;
    logic [smta_pkg::CNT_W-1:0]  self_count;
    logic [smta_pkg::ACC_W-1:0]  self_y;
    logic [smta_pkg::ACC_W-1:0]  self_x;
    logic [smta_pkg::CNT_W-1:0]  raw_count;
    logic [smta_pkg::ACC_W-1:0]  raw_y;
    logic [smta_pkg::ACC_W-1:0]  raw_x;
  } tally_t;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] mx;
    logic [15:0] my;
    logic [31:0] stamp;
    bit          typed;
    tally_t      want;
  } row_t;

  logic clk = 0, rst = 1;
  logic s_axis_tvalid = 0, m_axis_tready = 0, cfg_valid = 0;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0, cfg_index = '0;
  logic [19:0] cfg_data = '0;
  logic s_axis_tready, m_axis_tvalid, cfg_ready;
  logic [239:0] m_axis_tdata;

  self_motion_tagging_accumulator uut (.*);

  initial forever #5 clk = ~clk;

  // predictor state
  logic [19:0] match_win, late_win, hist_win;
  logic [31:0] obs_mv[$], obs_t[$];
  bit          obs_self[$];
  logic [31:0] inj_mv[$], inj_t[$];
  logic [31:0] last_take;
  tally_t      pending_tallies[$];

  int mismatches = 0, cycles = 0;
  bit calm = 0;

  function automatic bit aged(logic [31:0] t, logic [31:0] now, logic [19:0] w);
    return now > t && now - t > w;
  endfunction

  function automatic void drop_oldest_obs();
    obs_mv.delete(0); obs_t.delete(0); obs_self.delete(0);
  endfunction

  function automatic void drop_oldest_inj();
    inj_mv.delete(0); inj_t.delete(0);
  endfunction

  function automatic void age_out(logic [31:0] now);
    while (obs_t.size() > 0 && aged(obs_t[0], now, hist_win)) drop_oldest_obs();
    while (inj_t.size() > 0 && aged(inj_t[0], now, match_win)) drop_oldest_inj();
  endfunction

  function automatic void tally_window(logic [31:0] now);
    longint start, len, rx, ry, sx, sy, hx, hy;
    int rc, sc;
    logic [31:0] smp;
    tally_t r;
    start = longint'(now) - longint'(hist_win);
    rx = 0; ry = 0; sx = 0; sy = 0; hx = 0; hy = 0; rc = 0; sc = 0; smp = now;
    if (longint'(last_take) > start) start = longint'(last_take);
    len = longint'(now) - start;
    if (len < smta_pkg::WIN_MIN_US) len = smta_pkg::WIN_MIN_US;
    if (len > smta_pkg::WIN_MAX_US) len = smta_pkg::WIN_MAX_US;
    foreach (obs_t[i]) begin
      if (longint'(obs_t[i]) > start && obs_t[i] <= now) begin
        rx += $signed(obs_mv[i][15:0]); ry += $signed(obs_mv[i][31:16]); rc++;
        if (obs_self[i]) begin
          sx += $signed(obs_mv[i][15:0]); sy += $signed(obs_mv[i][31:16]); sc++;
        end else begin
          hx += $signed(obs_mv[i][15:0]); hy += $signed(obs_mv[i][31:16]); smp = obs_t[i];
        end
      end
    end
    last_take = now;
    while (obs_t.size() > 0 && obs_t[0] <= now) drop_oldest_obs();
    r.raw_x = rx[26:0]; r.raw_y = ry[26:0]; r.raw_count = rc[11:0];
    r.self_x = sx[26:0]; r.self_y = sy[26:0]; r.self_count = sc[11:0];
    r.manual_x = hx[26:0]; r.manual_y = hy[26:0];
    r.sample_time = smp; r.window_length = len[16:0];
    pending_tallies.insert(pending_tallies.size(), r);
  endfunction

  function automatic void predict(logic [1:0] op, logic [31:0] mv, logic [31:0] now);
    bit hit;
    hit = 0;
    if (op == smta_pkg::OP_CLEAR) begin
      obs_mv.delete(); obs_t.delete(); obs_self.delete();
      inj_mv.delete(); inj_t.delete(); last_take = now;
      return;
    end
    if (op == smta_pkg::OP_CONSUME) begin
      age_out(now); tally_window(now);
      return;
    end
    if (mv == 0) return;
    age_out(now);
    if (op == smta_pkg::OP_RECORD) begin
      for (int i = obs_t.size() - 1; i >= 0 && !hit; i--)
        if (!obs_self[i] && obs_mv[i] == mv && obs_t[i] <= now && now - obs_t[i] <= late_win) begin
          obs_self[i] = 1; hit = 1;
        end
      if (!hit) begin
        if (inj_t.size() >= smta_pkg::EXP_DEPTH) drop_oldest_inj();
        inj_mv.insert(inj_mv.size(), mv); inj_t.insert(inj_t.size(), now);
      end
    end else begin
      for (int k = 0; k < inj_t.size() && !hit; k++)
        if (inj_mv[k] == mv && now >= inj_t[k] && now - inj_t[k] <= match_win) begin
          inj_mv.delete(k); inj_t.delete(k); hit = 1;
        end
      if (obs_t.size() >= smta_pkg::OBS_DEPTH) drop_oldest_obs();
      obs_mv.insert(obs_mv.size(), mv); obs_t.insert(obs_t.size(), now);
      obs_self.insert(obs_self.size(), hit);
    end
  endfunction

  // result side: random stalls, compare at the rising edge
  initial begin
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      m_axis_tready <= 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_tallies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        automatic tally_t e = pending_tallies[0];
        pending_tallies.delete(0);
        if (tally_t'(m_axis_tdata[234:0]) !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %p got %p", e, tally_t'(m_axis_tdata[234:0]));
        end
      end
    end
    if (cycles > 3000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    @(negedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
    if (idx == smta_pkg::REG_SELF_MATCH) match_win = val;
    else if (idx == smta_pkg::REG_LATE) late_win = val;
    else if (idx == smta_pkg::REG_HISTORY) hist_win = val;
  endtask

  task automatic send_item(logic [1:0] op, logic [15:0] mx, logic [15:0] my,
                           logic [31:0] stamp);
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_axis_tvalid <= 1; s_axis_tuser <= op; s_axis_tdata <= {stamp, my, mx};
    do @(posedge clk); while (!s_axis_tready);
    predict(op, {my, mx}, stamp);
    @(negedge clk);
    s_axis_tvalid <= 0;
  endtask

  task automatic drain();
    while (pending_tallies.size() > 0) @(negedge clk);
    repeat (4200) @(negedge clk);
  endtask

  row_t plan[$];
  logic [31:0] now;

  function automatic row_t mk(logic [1:0] op, logic [15:0] mx, logic [15:0] my,
                              logic [31:0] st);
    row_t r;
    r.op = op; r.mx = mx; r.my = my; r.stamp = st; r.typed = 0; r.want = '0;
    return r;
  endfunction

  initial begin
    row_t r;
    logic [1:0] op;
    logic [15:0] mx, my;
    match_win = smta_pkg::SELF_MATCH_RST; late_win = smta_pkg::LATE_RST;
    hist_win = smta_pkg::HISTORY_RST;
    last_take = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // consume right after reset: empty window, length at the upper bound
    r = mk(smta_pkg::OP_CONSUME, 0, 0, 32'd500000); r.typed = 1;
    r.want = '0; r.want.sample_time = 32'd500000; r.want.window_length = 17'd100000;
    plan.insert(plan.size(), r);
    plan.insert(plan.size(), mk(smta_pkg::OP_OBSERVE, 16'h7fff, 16'h8000, 32'd500100));
    plan.insert(plan.size(), mk(smta_pkg::OP_OBSERVE, 16'h8000, 16'h7fff, 32'd500200));
    plan.insert(plan.size(), mk(smta_pkg::OP_OBSERVE, 16'hffff, 16'h0000, 32'd500250));
    plan.insert(plan.size(), mk(smta_pkg::OP_RECORD, 16'h0005, 16'h0003, 32'd500300));
    plan.insert(plan.size(), mk(smta_pkg::OP_OBSERVE, 16'h0005, 16'h0003, 32'd500400));
    plan.insert(plan.size(), mk(smta_pkg::OP_OBSERVE, 16'h0009, 16'hfffe, 32'd500500));
    plan.insert(plan.size(), mk(smta_pkg::OP_RECORD, 16'h0009, 16'hfffe, 32'd500600));
    plan.insert(plan.size(), mk(smta_pkg::OP_OBSERVE, 16'h0000, 16'h0000, 32'd500700));
    plan.insert(plan.size(), mk(smta_pkg::OP_RECORD, 16'h0000, 16'h0000, 32'd500700));
    plan.insert(plan.size(), mk(smta_pkg::OP_OBSERVE, 16'h0001, 16'h0001, 32'd400000));
    plan.insert(plan.size(), mk(smta_pkg::OP_CONSUME, 0, 0, 32'd500800));
    // start equal to stamp gives the short clamp
    r = mk(smta_pkg::OP_CONSUME, 0, 0, 32'd500800); r.typed = 1;
    r.want = '0; r.want.sample_time = 32'd500800; r.want.window_length = 17'd1000;
    plan.insert(plan.size(), r);
    plan.insert(plan.size(), mk(smta_pkg::OP_CLEAR, 0, 0, 32'd10));
    plan.insert(plan.size(), mk(smta_pkg::OP_OBSERVE, 16'h0002, 16'h0000, 32'd20));
    plan.insert(plan.size(), mk(smta_pkg::OP_RECORD, 16'h0003, 16'h0000, 32'd30));
    plan.insert(plan.size(), mk(smta_pkg::OP_CONSUME, 0, 0, 32'd50));
    plan.insert(plan.size(), mk(smta_pkg::OP_OBSERVE, 16'h0003, 16'h0000, 32'd90000));
    plan.insert(plan.size(), mk(smta_pkg::OP_CONSUME, 16'h1234, 16'h5678, 32'hffffffff));
    plan.insert(plan.size(), mk(smta_pkg::OP_CLEAR, 0, 0, 32'hfffff000));
    plan.insert(plan.size(), mk(smta_pkg::OP_OBSERVE, 16'h5555, 16'haaaa, 32'hfffff800));
    plan.insert(plan.size(), mk(smta_pkg::OP_CONSUME, 0, 0, 32'hffffffff));

    foreach (plan[i]) begin
      send_item(plan[i].op, plan[i].mx, plan[i].my, plan[i].stamp);
      if (plan[i].typed && pending_tallies[$] !== plan[i].want) begin
        mismatches++;
        if (mismatches <= 10) $display("row %0d exp %p", i, plan[i].want);
      end
    end
    drain();

    now = 32'd1000;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(smta_pkg::REG_SELF_MATCH, 20'd0); write_reg(smta_pkg::REG_LATE, 20'd0);
          write_reg(smta_pkg::REG_HISTORY, 20'd1000);
        end
        1: begin
          write_reg(smta_pkg::REG_SELF_MATCH, 20'd1000000);
          write_reg(smta_pkg::REG_LATE, 20'd1000000);
          write_reg(smta_pkg::REG_HISTORY, 20'd1000000);
        end
        2: begin
          write_reg(smta_pkg::REG_SELF_MATCH, 20'd3000); write_reg(smta_pkg::REG_LATE, 20'd2000);
          write_reg(smta_pkg::REG_HISTORY, 20'd8000);
        end
        default: begin
          write_reg(smta_pkg::REG_SELF_MATCH, smta_pkg::SELF_MATCH_RST);
          write_reg(smta_pkg::REG_LATE, smta_pkg::LATE_RST);
          write_reg(smta_pkg::REG_HISTORY, smta_pkg::HISTORY_RST);
          write_reg(REG_UNUSED, 20'hfffff);
          calm = 1;
        end
      endcase
      for (int n = 0; n < 29; n++) begin
        op = $urandom_range(0, 9) < 4 ? smta_pkg::OP_OBSERVE :
             ($urandom_range(0, 2) == 0 ? smta_pkg::OP_CONSUME : smta_pkg::OP_RECORD);
        if ($urandom_range(0, 30) == 0) op = smta_pkg::OP_CLEAR;
        if ($urandom_range(0, 3) == 0) begin
          mx = 16'($urandom); my = 16'($urandom);
        end else begin
          mx = 16'($urandom_range(0, 3) - 1); my = 16'($urandom_range(0, 2) - 1);
        end
        if ($urandom_range(0, 15) == 0) now = now - $urandom_range(0, 3000);
        else now = now + $urandom_range(0, 2500);
        if ($urandom_range(0, 40) == 0) now = $urandom;
        send_item(op, mx, my, now);
        if (n == 18 && phase == 1) while (pending_tallies.size() > 0) @(negedge clk);
      end
      drain();
    end

    if (mismatches == 0 && pending_tallies.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
